### hdl/pidvi_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the microcode table of the variable-interval PID block.
package pidvi_pkg;

  // Field and datapath widths.
  localparam int unsigned ValW   = 16;
  localparam int unsigned TickW  = 32;
  localparam int unsigned GainW  = 32;
  localparam int unsigned ErrW   = ValW + 1;
  localparam int unsigned DerrW  = ErrW + 1;
  localparam int unsigned IntegW = 48;
  localparam int unsigned MulW   = 33;
  localparam int unsigned ProdW  = 2 * MulW;
  localparam int unsigned AccW   = 80;
  localparam int unsigned DriveW = 32;
  localparam int unsigned DivW   = 48;
  localparam int unsigned QuotW  = DivW + 1;
  localparam int unsigned CntW   = $clog2(DivW + 1);
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned PcW    = 4;

  // Gain reset values, signed Q16.16.
  localparam logic signed [GainW-1:0] KpReset = 32'sd13107;
  localparam logic signed [GainW-1:0] KiReset = 32'sd0;
  localparam logic signed [GainW-1:0] KdReset = 32'sd66;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgKp = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgKi = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgKd = 2'd2;

  // Microcode step addresses.
  localparam logic [PcW-1:0] StepWait     = 4'd0;
  localparam logic [PcW-1:0] StepErrElap  = 4'd1;
  localparam logic [PcW-1:0] StepInteg    = 4'd2;
  localparam logic [PcW-1:0] StepKdDerr   = 4'd3;
  localparam logic [PcW-1:0] StepDivStart = 4'd4;
  localparam logic [PcW-1:0] StepDivWait  = 4'd5;
  localparam logic [PcW-1:0] StepQuot     = 4'd6;
  localparam logic [PcW-1:0] StepClear    = 4'd7;
  localparam logic [PcW-1:0] StepKiLo     = 4'd8;
  localparam logic [PcW-1:0] StepKiHi     = 4'd9;
  localparam logic [PcW-1:0] StepAddHi    = 4'd10;
  localparam logic [PcW-1:0] StepOut      = 4'd11;

  typedef enum logic [2:0] {
    COND_SEQ,
    COND_JMP,
    COND_JMP_ZERO,
    COND_WAIT_IN,
    COND_WAIT_DIV,
    COND_WAIT_OUT
  } cond_e;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_ERR_ELAP,
    MUL_KD_DERR,
    MUL_KP_ERR,
    MUL_KI_LO,
    MUL_KI_HI
  } mul_sel_e;

  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_CLEAR,
    ACC_QUOT,
    ACC_ADD,
    ACC_ADD_HI
  } acc_op_e;

  typedef struct packed {
    cond_e          cond;
    logic [PcW-1:0] target;
    mul_sel_e       mul_sel;
    acc_op_e        acc_op;
    logic           integ_upd;
    logic           div_start;
    logic           out_load;
  } ctrl_t;

  typedef struct packed {
    logic in_accept;
    logic zero;
    logic div_busy;
    logic out_blocked;
  } seq_stat_t;

  function automatic ctrl_t cw(input cond_e c, input logic [PcW-1:0] tgt,
                               input mul_sel_e m, input acc_op_e a,
                               input logic iu, input logic ds, input logic ol);
    ctrl_t w;
    w.cond      = c;
    w.target    = tgt;
    w.mul_sel   = m;
    w.acc_op    = a;
    w.integ_upd = iu;
    w.div_start = ds;
    w.out_load  = ol;
    return w;
  endfunction

  // Control store: one word per step.
  function automatic ctrl_t ucode(input logic [PcW-1:0] pc);
    ctrl_t w;
    unique case (pc)
      StepWait:     w = cw(COND_WAIT_IN,  StepWait,  MUL_NONE,     ACC_HOLD,   1'b0, 1'b0, 1'b0);
      StepErrElap:  w = cw(COND_SEQ,      StepWait,  MUL_ERR_ELAP, ACC_HOLD,   1'b0, 1'b0, 1'b0);
      StepInteg:    w = cw(COND_SEQ,      StepWait,  MUL_NONE,     ACC_HOLD,   1'b1, 1'b0, 1'b0);
      StepKdDerr:   w = cw(COND_SEQ,      StepWait,  MUL_KD_DERR,  ACC_HOLD,   1'b0, 1'b0, 1'b0);
      StepDivStart: w = cw(COND_JMP_ZERO, StepClear, MUL_NONE,     ACC_HOLD,   1'b0, 1'b1, 1'b0);
      StepDivWait:  w = cw(COND_WAIT_DIV, StepWait,  MUL_NONE,     ACC_HOLD,   1'b0, 1'b0, 1'b0);
      StepQuot:     w = cw(COND_JMP,      StepKiLo,  MUL_KP_ERR,   ACC_QUOT,   1'b0, 1'b0, 1'b0);
      StepClear:    w = cw(COND_SEQ,      StepWait,  MUL_KP_ERR,   ACC_CLEAR,  1'b0, 1'b0, 1'b0);
      StepKiLo:     w = cw(COND_SEQ,      StepWait,  MUL_KI_LO,    ACC_ADD,    1'b0, 1'b0, 1'b0);
      StepKiHi:     w = cw(COND_SEQ,      StepWait,  MUL_KI_HI,    ACC_ADD,    1'b0, 1'b0, 1'b0);
      StepAddHi:    w = cw(COND_SEQ,      StepWait,  MUL_NONE,     ACC_ADD_HI, 1'b0, 1'b0, 1'b0);
      StepOut:      w = cw(COND_WAIT_OUT, StepWait,  MUL_NONE,     ACC_HOLD,   1'b0, 1'b0, 1'b1);
      default:      w = cw(COND_JMP,      StepWait,  MUL_NONE,     ACC_HOLD,   1'b0, 1'b0, 1'b0);
    endcase
    return w;
  endfunction

endpackage

### hdl/pidvi_if.sv
`timescale 1ns / 1ps
// Channel interfaces: input items, result items and configuration writes.
interface pidvi_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] measured_value;
  logic signed [15:0] target_value;
  logic [31:0]        tick_now;

  modport source(output valid, measured_value, target_value, tick_now, input ready);
  modport sink(input valid, measured_value, target_value, tick_now, output ready);
endinterface

interface pidvi_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] drive_value;
  logic               drive_saturated;
  logic               zero_interval;

  modport source(output valid, drive_value, drive_saturated, zero_interval, input ready);
  modport sink(input valid, drive_value, drive_saturated, zero_interval, output ready);
endinterface

interface pidvi_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

### hdl/pid_controller_variable_interval.sv
`timescale 1ns / 1ps
// Top level of the PID controller with a measured time step.
//
// Usage:
//   in_i   carries one beat per control update: measured value, target value and
//          the free-running millisecond tick. ready is high only while the
//          sequencer waits for work, so one item is in flight at a time.
//   out_o  returns one beat per input: the saturated Q16.16 drive, a saturation
//          flag (drive or integral clamped) and a flag for a zero interval.
//   cfg_i  writes the kp, ki and kd gains (index 0, 1, 2); always ready. Write
//          only while the block is idle.
// Timing: a normal item runs the restoring divider of the derivative term between
//   its input beat and its result beat; the next input beat can be taken on the
//   same edge as the result beat, but not before the result of the current item
//   is loaded. A zero interval skips the divider.
// Reset clears the gains to their defaults and the tick, error and integral
//   history to zero. A result beat that is not taken holds in the output
//   register; the next item may be accepted and run behind it and then waits in
//   its final step until the register frees.
module pid_controller_variable_interval (
  input logic        clk_i,
  input logic        rst_ni,
  pidvi_in_if.sink   in_i,
  pidvi_out_if.source out_o,
  pidvi_cfg_if.sink  cfg_i
);
  import pidvi_pkg::*;

  // Gain registers.
  logic signed [GainW-1:0] kp_q, ki_q, kd_q;

  // Controller history.
  logic [TickW-1:0]         prev_tick_q;
  logic signed [IntegW-1:0] integ_q;
  logic signed [ErrW-1:0]   prev_err_q;

  // Per-item working registers.
  logic signed [ErrW-1:0]   err_q;
  logic signed [DerrW-1:0]  derr_q;
  logic [TickW-1:0]         elapsed_q;
  logic                     zero_q;
  logic                     sat_q;
  logic signed [ProdW-1:0]  prod_q;
  logic signed [AccW-1:0]   acc_q;

  // Result register.
  logic                     out_valid_q;
  logic signed [DriveW-1:0] drive_q;
  logic                     out_sat_q;
  logic                     out_zero_q;

  ctrl_t                    ctrl;
  seq_stat_t                stat;
  logic                     in_accept;
  logic                     out_accept;
  logic                     out_blocked;
  logic                     out_load;
  logic                     div_start;
  logic                     div_busy;
  logic signed [QuotW-1:0]  quotient;

  logic signed [ErrW-1:0]   err_new;
  logic signed [MulW-1:0]   mul_a, mul_b;
  logic signed [IntegW+1:0] integ_sum;
  logic                     integ_pos_ovf, integ_neg_ovf;
  logic                     drive_pos_ovf, drive_neg_ovf;
  logic signed [DriveW-1:0] drive_sat;

  // Handshakes.
  assign in_i.ready  = (ctrl.cond == COND_WAIT_IN);
  assign cfg_i.ready = 1'b1;
  assign in_accept   = in_i.valid && in_i.ready;
  assign out_accept  = out_o.valid && out_o.ready;
  assign out_blocked = out_valid_q && !out_o.ready;
  assign out_load    = ctrl.out_load && !out_blocked;
  assign div_start   = ctrl.div_start && !zero_q;

  assign stat.in_accept   = in_accept;
  assign stat.zero        = zero_q;
  assign stat.div_busy    = div_busy;
  assign stat.out_blocked = out_blocked;

  pidvi_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  // Derivative term: kd * error change over elapsed ticks.
  pidvi_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod_q[QuotW-1:0]),
    .divisor_i  (elapsed_q),
    .busy_o     (div_busy),
    .quotient_o (quotient)
  );

  assign err_new = {in_i.target_value[ValW-1], in_i.target_value}
                 - {in_i.measured_value[ValW-1], in_i.measured_value};

  // Shared multiplier operand select.
  always_comb begin
    unique case (ctrl.mul_sel)
      MUL_ERR_ELAP: begin
        mul_a = {{(MulW-ErrW){err_q[ErrW-1]}}, err_q};
        mul_b = {1'b0, elapsed_q};
      end
      MUL_KD_DERR: begin
        mul_a = {kd_q[GainW-1], kd_q};
        mul_b = {{(MulW-DerrW){derr_q[DerrW-1]}}, derr_q};
      end
      MUL_KP_ERR: begin
        mul_a = {kp_q[GainW-1], kp_q};
        mul_b = {{(MulW-ErrW){err_q[ErrW-1]}}, err_q};
      end
      MUL_KI_LO: begin
        mul_a = {ki_q[GainW-1], ki_q};
        mul_b = {{(MulW-IntegW/2){1'b0}}, integ_q[IntegW/2-1:0]};
      end
      MUL_KI_HI: begin
        mul_a = {ki_q[GainW-1], ki_q};
        mul_b = {{(MulW-IntegW/2){integ_q[IntegW-1]}}, integ_q[IntegW-1:IntegW/2]};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Integral update with clamp to the 48-bit range.
  assign integ_sum     = {{2{integ_q[IntegW-1]}}, integ_q} + prod_q[IntegW+1:0];
  assign integ_pos_ovf = !integ_sum[IntegW+1] && (|integ_sum[IntegW:IntegW-1]);
  assign integ_neg_ovf = integ_sum[IntegW+1] && !(&integ_sum[IntegW:IntegW-1]);

  // Drive clamp to 32 bits.
  assign drive_pos_ovf = !acc_q[AccW-1] && (|acc_q[AccW-2:DriveW-1]);
  assign drive_neg_ovf = acc_q[AccW-1] && !(&acc_q[AccW-2:DriveW-1]);
  always_comb begin
    priority if (drive_pos_ovf) begin
      drive_sat = {1'b0, {(DriveW-1){1'b1}}};
    end else if (drive_neg_ovf) begin
      drive_sat = {1'b1, {(DriveW-1){1'b0}}};
    end else begin
      drive_sat = acc_q[DriveW-1:0];
    end
  end

  // Gains and history: control state, cleared by reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q        <= KpReset;
      ki_q        <= KiReset;
      kd_q        <= KdReset;
      prev_tick_q <= '0;
      integ_q     <= '0;
      prev_err_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        unique case (cfg_i.index)
          CfgKp:   kp_q <= cfg_i.data;
          CfgKi:   ki_q <= cfg_i.data;
          CfgKd:   kd_q <= cfg_i.data;
          default: ;
        endcase
      end
      if (in_accept) begin
        prev_tick_q <= in_i.tick_now;
      end
      if (ctrl.integ_upd) begin
        priority if (integ_pos_ovf) begin
          integ_q <= {1'b0, {(IntegW-1){1'b1}}};
        end else if (integ_neg_ovf) begin
          integ_q <= {1'b1, {(IntegW-1){1'b0}}};
        end else begin
          integ_q <= integ_sum[IntegW-1:0];
        end
        prev_err_q <= err_q;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_accept) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working and result payload.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      err_q     <= err_new;
      elapsed_q <= in_i.tick_now - prev_tick_q;
      zero_q    <= (in_i.tick_now == prev_tick_q);
      sat_q     <= 1'b0;
    end
    if (ctrl.integ_upd) begin
      derr_q <= {err_q[ErrW-1], err_q} - {prev_err_q[ErrW-1], prev_err_q};
      if (integ_pos_ovf || integ_neg_ovf) begin
        sat_q <= 1'b1;
      end
    end
    if (ctrl.mul_sel != MUL_NONE) begin
      prod_q <= mul_a * mul_b;
    end
    unique case (ctrl.acc_op)
      ACC_CLEAR:  acc_q <= '0;
      ACC_QUOT:   acc_q <= {{(AccW-QuotW){quotient[QuotW-1]}}, quotient};
      ACC_ADD:    acc_q <= acc_q + {{(AccW-ProdW){prod_q[ProdW-1]}}, prod_q};
      ACC_ADD_HI: acc_q <= acc_q + {prod_q[AccW-IntegW/2-1:0], {(IntegW/2){1'b0}}};
      default:    ;
    endcase
    if (out_load) begin
      drive_q    <= drive_sat;
      out_sat_q  <= sat_q || drive_pos_ovf || drive_neg_ovf;
      out_zero_q <= zero_q;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.drive_value     = drive_q;
  assign out_o.drive_saturated = out_sat_q;
  assign out_o.zero_interval   = out_zero_q;

  // The divider is idle whenever a new item enters.
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_accept |-> !div_busy)
    else $error("input beat accepted while divider busy");

  // A taken input beat moves the sequencer off the wait step.
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_accept |=> !in_i.ready)
    else $error("sequencer did not leave wait step after input beat");

  // A loaded result is offered on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) out_load |=> out_o.valid)
    else $error("loaded result not presented");

  // The divider never starts on a zero interval.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (ctrl.div_start && zero_q) |=> !div_busy)
    else $error("divider started on zero interval");

endmodule

### hdl/pidvi_div.sv
`timescale 1ns / 1ps
// Radix-2 restoring divider: signed dividend by unsigned divisor, truncated toward zero.
module pidvi_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic signed [pidvi_pkg::QuotW-1:0] dividend_i,
  input  logic [pidvi_pkg::TickW-1:0]        divisor_i,
  output logic                              busy_o,
  output logic signed [pidvi_pkg::QuotW-1:0] quotient_o
);
  import pidvi_pkg::*;

  logic              busy_q;
  logic [CntW-1:0]   cnt_q;
  logic [TickW-1:0]  rem_q;
  logic [DivW-1:0]   quo_q;
  logic [TickW-1:0]  dvs_q;
  logic              neg_q;

  logic [QuotW-1:0]  abs_dividend;
  logic [TickW:0]    shifted;
  logic [TickW:0]    diff;
  logic              ge;

  assign abs_dividend = dividend_i[QuotW-1] ? (QuotW'(0) - QuotW'(dividend_i))
                                            : QuotW'(dividend_i);
  assign shifted = {rem_q, quo_q[DivW-1]};
  assign diff    = shifted - {1'b0, dvs_q};
  assign ge      = (shifted >= {1'b0, dvs_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CntW'(DivW);
    end else if (busy_q) begin
      cnt_q  <= cnt_q - CntW'(1);
      busy_q <= (cnt_q != CntW'(1));
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= abs_dividend[DivW-1:0];
      dvs_q <= divisor_i;
      neg_q <= dividend_i[QuotW-1];
    end else if (busy_q) begin
      rem_q <= ge ? diff[TickW-1:0] : shifted[TickW-1:0];
      quo_q <= {quo_q[DivW-2:0], ge};
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});

endmodule

### hdl/pidvi_seq.sv
`timescale 1ns / 1ps
// Microcode sequencer: step counter, control store lookup and jump logic.
module pidvi_seq (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pidvi_pkg::seq_stat_t stat_i,
  output pidvi_pkg::ctrl_t     ctrl_o
);
  import pidvi_pkg::*;

  logic [PcW-1:0] pc_q;
  logic [PcW-1:0] pc_d;
  logic [PcW-1:0] pc_inc;
  ctrl_t          ctrl;

  assign ctrl   = ucode(pc_q);
  assign pc_inc = pc_q + PcW'(1);

  always_comb begin
    unique case (ctrl.cond)
      COND_SEQ:      pc_d = pc_inc;
      COND_JMP:      pc_d = ctrl.target;
      COND_JMP_ZERO: pc_d = stat_i.zero ? ctrl.target : pc_inc;
      COND_WAIT_IN:  pc_d = stat_i.in_accept ? pc_inc : pc_q;
      COND_WAIT_DIV: pc_d = stat_i.div_busy ? pc_q : pc_inc;
      COND_WAIT_OUT: pc_d = stat_i.out_blocked ? pc_q : ctrl.target;
      default:       pc_d = StepWait;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= StepWait;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign ctrl_o = ctrl;

endmodule

### sim/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the variable-interval PID controller.
module tb;
  import pidvi_pkg::*;

  // Limits of the integral store and of the drive output.
  localparam longint IntegMax = 64'sd140737488355327;
  localparam longint IntegMin = -64'sd140737488355328;
  localparam longint DriveMax = 64'sd2147483647;
  localparam longint DriveMin = -64'sd2147483648;

  // Index past the last gain register; a write there must change nothing.
  localparam logic [CfgIdxW-1:0] CfgUnused = 2'd3;

  localparam int LongHoldCycles = 400;
  localparam int SettleCycles   = 20;
  localparam int TailCycles     = 100;
  localparam int NumPhases      = 7;

  typedef struct packed {
    logic signed [31:0] drive;
    logic               sat;
    logic               zero;
  } drive_rec_t;

  typedef struct packed {
    logic [15:0] measured;
    logic [15:0] target;
    logic [31:0] tick;
  } stim_item_t;

  typedef enum int {RX_FREE, RX_COIN, RX_BURSTY} rx_mode_e;

  // Tracks gains and loop history, predicts one drive beat per input beat
  // and checks the result beats in order against it.
  class drive_scoreboard;
    logic signed [31:0] kp, ki, kd;
    logic [31:0]        last_tick;
    logic signed [47:0] integ_acc;
    logic signed [16:0] last_err;
    drive_rec_t         pending_drives[$];
    int                 mismatches;

    function new();
      kp = KpReset;
      ki = KiReset;
      kd = KdReset;
      last_tick = '0;
      integ_acc = '0;
      last_err = '0;
      mismatches = 0;
    endfunction

    function void set_gain(input logic [CfgIdxW-1:0] idx, input logic [31:0] val);
      case (idx)
        CfgKp: kp = val;
        CfgKi: ki = val;
        CfgKd: kd = val;
        default: ;
      endcase
    endfunction

    function int outstanding();
      return pending_drives.size();
    endfunction

    function void take_sample(input logic [15:0] m, input logic [15:0] t,
                              input logic [31:0] tick);
      logic signed [16:0]  err;
      logic [31:0]         elapsed;
      logic signed [127:0] e_w, el_w, prev_w, acc_w, integ_w, d_w, sum_w;
      logic signed [127:0] kp_w, ki_w, kd_w;
      drive_rec_t          rec;
      err = {t[15], t} - {m[15], m};
      elapsed = tick - last_tick;
      e_w = err;
      el_w = {96'd0, elapsed};
      prev_w = last_err;
      acc_w = integ_acc;
      kp_w = kp;
      ki_w = ki;
      kd_w = kd;
      rec.sat = 1'b0;
      rec.zero = (elapsed == 32'd0);

      // Integral of error over ticks, clamped at the 48-bit limits.
      integ_w = acc_w + e_w * el_w;
      if (integ_w > IntegMax) begin
        integ_w = IntegMax;
        rec.sat = 1'b1;
      end else if (integ_w < IntegMin) begin
        integ_w = IntegMin;
        rec.sat = 1'b1;
      end

      // Derivative term truncates toward zero; a zero interval drops it.
      if (rec.zero) begin
        d_w = '0;
      end else begin
        d_w = (kd_w * (e_w - prev_w)) / el_w;
      end

      sum_w = kp_w * e_w + ki_w * integ_w + d_w;
      if (sum_w > DriveMax) begin
        sum_w = DriveMax;
        rec.sat = 1'b1;
      end else if (sum_w < DriveMin) begin
        sum_w = DriveMin;
        rec.sat = 1'b1;
      end
      rec.drive = sum_w[31:0];

      integ_acc = integ_w[47:0];
      last_err = err;
      last_tick = tick;
      pending_drives.push_back(rec);
    endfunction

    function void check_drive(input logic [31:0] d, input logic s, input logic z);
      drive_rec_t want;
      if (pending_drives.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result beat with nothing pending: drive %h sat %b zero %b",
                   $realtime, d, s, z);
        return;
      end
      want = pending_drives.pop_front();
      if (want.drive !== d || want.sat !== s || want.zero !== z) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: drive mismatch: expected %h sat %b zero %b, got %h sat %b zero %b",
                   $realtime, want.drive, want.sat, want.zero, d, s, z);
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  pidvi_in_if  in_ch();
  pidvi_out_if out_ch();
  pidvi_cfg_if cfg_ch();

  pid_controller_variable_interval u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  drive_scoreboard sb;
  stim_item_t      batch_q[$];
  logic [31:0]     stim_tick;
  rx_mode_e        rx_mode;
  int              hold_req_cnt;

  // 8 ns clock.
  initial clk_i = 1'b0;
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #6_000_000;
    $display("pid_controller_variable_interval test failed");
    $finish;
  end

  // Sample every handshake at the clock edge. Check result beats before
  // noting the input beat of the same edge, which is always the younger item.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready)
        sb.check_drive(out_ch.drive_value, out_ch.drive_saturated, out_ch.zero_interval);
      if (in_ch.valid && in_ch.ready)
        sb.take_sample(in_ch.measured_value, in_ch.target_value, in_ch.tick_now);
      if (cfg_ch.valid && cfg_ch.ready)
        sb.set_gain(cfg_ch.index, cfg_ch.data);
    end
  end

  // Result receiver: stalls on its own pattern, and on request holds off for
  // a long stretch so the block backs up and stalls its input.
  initial begin
    int stall_left;
    int hold_left;
    int hold_done_cnt;
    stall_left = 0;
    hold_left = 0;
    hold_done_cnt = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (hold_done_cnt != hold_req_cnt) begin
        hold_done_cnt++;
        hold_left = LongHoldCycles;
        out_ch.ready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_COIN: out_ch.ready <= ($urandom_range(0, 3) != 0);
          RX_BURSTY: begin
            if (stall_left > 0) begin
              stall_left--;
              out_ch.ready <= 1'b0;
            end else begin
              out_ch.ready <= 1'b1;
              if ($urandom_range(0, 99) < 15) stall_left = $urandom_range(1, 70);
            end
          end
          default: out_ch.ready <= 1'b1;
        endcase
      end
    end
  end

  // Write one gain register; drop valid after the beat and wait for the next edge,
  // so back-to-back calls never lower and raise valid in the same step.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] val);
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    cfg_ch.valid <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    cfg_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Offer every queued item in order. With idling on, the items go out in
  // bursts of random length separated by random gaps.
  task automatic send_batch(input bit idle);
    int         burst_left;
    int         gap;
    stim_item_t it;
    burst_left = idle ? $urandom_range(1, 8) : 32'h4000_0000;
    while (batch_q.size() != 0) begin
      it = batch_q.pop_front();
      in_ch.measured_value <= it.measured;
      in_ch.target_value   <= it.target;
      in_ch.tick_now       <= it.tick;
      in_ch.valid          <= 1'b1;
      @(posedge clk_i);
      while (!in_ch.ready) @(posedge clk_i);
      burst_left--;
      if (burst_left == 0) begin
        in_ch.valid <= 1'b0;
        gap = ($urandom_range(0, 1) != 0) ? $urandom_range(1, 5) : $urandom_range(1, 90);
        repeat (gap) @(posedge clk_i);
        burst_left = $urandom_range(1, 8);
      end
    end
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Hold the sender until every pending drive has come back, then settle.
  task automatic wait_idle();
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic push_item(input logic [15:0] m, input logic [15:0] t, input logic [31:0] tick);
    stim_item_t it;
    it.measured = m;
    it.target   = t;
    it.tick     = tick;
    batch_q.push_back(it);
    stim_tick = tick;
  endtask

  initial begin
    logic [31:0] kp_v, ki_v, kd_v;
    logic [15:0] mv, tv;
    logic [31:0] dt;
    int          n_items;
    int          sel;
    bit          tx_idle;

    sb = new();
    hold_req_cnt = 0;
    rx_mode = RX_FREE;
    stim_tick = '0;
    in_ch.valid          <= 1'b0;
    in_ch.measured_value <= '0;
    in_ch.target_value   <= '0;
    in_ch.tick_now       <= '0;
    cfg_ch.valid         <= 1'b0;
    cfg_ch.index         <= '0;
    cfg_ch.data          <= '0;

    rst_ni <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at the reset gains.
    // First item after reset at tick 0: zero interval measured from reset.
    push_item(16'h0000, 16'h0000, 32'h0000_0000);
    // Largest positive error, then a full swing to the largest negative one.
    push_item(16'h8000, 16'h7FFF, 32'h0000_0001);
    push_item(16'h7FFF, 16'h8000, 32'h0000_0002);
    // Same tick again: zero interval with a large error.
    push_item(16'h7FFF, 16'h8000, 32'h0000_0002);
    // Huge interval drives the integral into its upper clamp.
    push_item(16'h8000, 16'h7FFF, 32'hFFFF_FFFF);
    // Tick wraps past zero; integral stays clamped.
    push_item(16'h8000, 16'h7FFF, 32'h0000_0005);
    push_item(16'h7FFF, 16'h8000, 32'h8000_0005);
    // Huge interval with negative error: integral falls close to, but short of, its lower clamp.
    push_item(16'h7FFF, 16'h8000, 32'h0000_0004);
    push_item(16'h0000, 16'h0000, 32'h0000_0004);
    push_item(16'h0064, 16'hFF9C, 32'h0000_0005);
    push_item(16'hFFFF, 16'h0000, 32'h0000_0006);
    push_item(16'h0000, 16'hFFFF, 32'hAAAA_AAAA);
    push_item(16'h5555, 16'hAAAA, 32'h5555_5555);
    push_item(16'hAAAA, 16'h5555, 32'h5555_5556);
    send_batch(1'b0);
    wait_idle();

    // Random phases, each under its own gains and idling pattern.
    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0: begin
          kp_v = 32'h7FFF_FFFF; ki_v = 32'h8000_0000; kd_v = 32'h7FFF_FFFF;
          rx_mode = RX_BURSTY; tx_idle = 1'b1; n_items = 80;
        end
        1: begin
          kp_v = 32'h8000_0000; ki_v = 32'h7FFF_FFFF; kd_v = 32'h8000_0000;
          rx_mode = RX_COIN; tx_idle = 1'b1; n_items = 80;
        end
        2: begin
          kp_v = 32'h0000_0000; ki_v = 32'h0000_0000; kd_v = 32'h0000_0000;
          rx_mode = RX_FREE; tx_idle = 1'b0; n_items = 60;
        end
        3: begin
          kp_v = $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
          ki_v = $urandom_range(0, 32'h0000_0400) - 32'h0000_0200;
          kd_v = $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
          rx_mode = RX_BURSTY; tx_idle = 1'b0; n_items = 120;
        end
        4: begin
          kp_v = $urandom; ki_v = $urandom; kd_v = $urandom;
          rx_mode = RX_COIN; tx_idle = 1'b1; n_items = 90;
        end
        5: begin
          kp_v = 32'h0000_0001; ki_v = 32'hFFFF_FFFF; kd_v = 32'h0000_0001;
          rx_mode = RX_BURSTY; tx_idle = 1'b1; n_items = 60;
        end
        default: begin
          kp_v = KpReset; ki_v = 32'h0000_0003; kd_v = KdReset;
          rx_mode = RX_BURSTY; tx_idle = 1'b1; n_items = 120;
        end
      endcase

      write_reg(CfgKp, kp_v);
      write_reg(CfgKi, ki_v);
      write_reg(CfgKd, kd_v);
      // The unused index must leave every gain untouched.
      if (ph == 2) write_reg(CfgUnused, $urandom);

      for (int k = 0; k < n_items; k++) begin
        sel = $urandom_range(0, 9);
        mv = $urandom;
        if (sel < 2) begin
          mv = ($urandom_range(0, 1) != 0) ? 16'h8000 : 16'h7FFF;
          tv = ($urandom_range(0, 1) != 0) ? ~mv : 16'($urandom);
        end else if (sel < 6) begin
          tv = mv + 16'($urandom_range(0, 200)) - 16'd100;
        end else begin
          tv = $urandom;
        end

        // Mostly short intervals, some zero, a few long or arbitrary jumps.
        sel = $urandom_range(0, 99);
        if (sel < 8) dt = 32'd0;
        else if (sel < 70) dt = $urandom_range(1, 20);
        else if (sel < 85) dt = $urandom_range(21, 5000);
        else if (sel < 93) dt = $urandom - stim_tick;
        else dt = $urandom;
        push_item(mv, tv, stim_tick + dt);
      end

      // Hold off the receiver while items keep coming so the block backs up.
      if (ph == 3) hold_req_cnt++;
      send_batch(tx_idle);
      wait_idle();
    end

    rx_mode = RX_FREE;
    repeat (TailCycles) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("pid_controller_variable_interval test passed");
    end else begin
      $display("pid_controller_variable_interval test failed");
    end
    $finish;
  end

endmodule

### sim.f
hdl/pidvi_pkg.sv
hdl/pidvi_if.sv
hdl/pidvi_div.sv
hdl/pidvi_seq.sv
hdl/pid_controller_variable_interval.sv
sim/tb.sv
